FILE: src/assert_macros.svh
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, disabled while in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: src/reco_pkg.sv
// ----------------------------------------------------------------------------
// reco_pkg
// Shared constants, codes and types of the rotary encoder counter.
// ----------------------------------------------------------------------------
package reco_pkg;

	localparam int MAG_BITS_DEF      = 24;
	localparam int INTERVAL_BITS_DEF = 16;
	localparam int SIG_W             = 5;
	localparam int CFG_IDX_W         = 3;

	// input commands
	localparam logic [1:0] CMD_US_TICK = 2'd0;
	localparam logic [1:0] CMD_MS_TICK = 2'd1;
	localparam logic [1:0] CMD_READ    = 2'd2;
	localparam logic [1:0] CMD_WRITE   = 2'd3;

	// result kinds
	localparam logic [1:0] KIND_READ   = 2'd0;
	localparam logic [1:0] KIND_ACK    = 2'd1;
	localparam logic [1:0] KIND_NOTIFY = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_INTERVAL = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOWER     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_UPPER     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_NOTIFY_ENABLE   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_NOTIFY_INTERVAL = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SIG_BITS        = 3'd5;

	typedef struct packed {
		logic       valid;
		logic [1:0] kind;
		logic       sign;
	} res_ctrl_t;

endpackage

FILE: src/rotary_encoder_counter_notify_unit.sv
// ----------------------------------------------------------------------------
// rotary_encoder_counter_notify_unit
// Rotary encoder position counter with read, write and change notification.
// ----------------------------------------------------------------------------
// Takes one command transaction per clock while in_stall is low: a
// transaction is captured in an input register, then the counter state is
// updated in a single pass through the engine, and a read reply, write
// acknowledge or notification is loaded into the output register on the
// same clock edge as that state update. Ticks that
// produce no result still pass through and never wait on the output side;
// the input stalls only while a held transaction needs the output register
// and a result there is stalled. Configuration writes take effect on the
// following clock and belong in idle periods.
`include "assert_macros.svh"

module rotary_encoder_counter_notify_unit #(
	parameter int MAG_BITS      = reco_pkg::MAG_BITS_DEF,
	parameter int INTERVAL_BITS = reco_pkg::INTERVAL_BITS_DEF,
	localparam int CFG_W = (MAG_BITS + 1 > INTERVAL_BITS) ? MAG_BITS + 1 : INTERVAL_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [reco_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]               cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [1:0]                     cmd,
	input  logic                           pin_a,
	input  logic                           pin_b,
	input  logic                           write_sign,
	input  logic [MAG_BITS-1:0]            write_magnitude,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [1:0]                     kind,
	output logic                           sign,
	output logic [MAG_BITS-1:0]            magnitude
);

	localparam logic [MAG_BITS:0] MAG_MAX_S = {1'b0, {MAG_BITS{1'b1}}};

	logic [INTERVAL_BITS-1:0]   sample_interval_q;
	logic signed [MAG_BITS:0]   range_lower_q;
	logic signed [MAG_BITS:0]   range_upper_q;
	logic                       notify_enable_q;
	logic [INTERVAL_BITS-1:0]   notify_interval_q;
	logic [reco_pkg::SIG_W-1:0] sig_bits_q;

	logic                       valid_s1;
	logic [1:0]                 cmd_s1;
	logic                       pin_a_s1, pin_b_s1, write_sign_s1;
	logic [MAG_BITS-1:0]        write_magnitude_s1;

	logic                       out_valid_q;
	logic [1:0]                 kind_q;
	logic                       sign_q;
	logic [MAG_BITS-1:0]        magnitude_q;

	logic                       go;
	reco_pkg::res_ctrl_t        res;
	logic [MAG_BITS-1:0]        res_mag;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_interval_q <= '0;
			range_lower_q     <= -MAG_MAX_S;
			range_upper_q     <= MAG_MAX_S;
			notify_enable_q   <= 1'b0;
			notify_interval_q <= '0;
			sig_bits_q        <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				reco_pkg::REG_SAMPLE_INTERVAL: sample_interval_q <= cfg_data[INTERVAL_BITS-1:0];
				reco_pkg::REG_RANGE_LOWER:     range_lower_q     <= cfg_data[MAG_BITS:0];
				reco_pkg::REG_RANGE_UPPER:     range_upper_q     <= cfg_data[MAG_BITS:0];
				reco_pkg::REG_NOTIFY_ENABLE:   notify_enable_q   <= cfg_data[0];
				reco_pkg::REG_NOTIFY_INTERVAL: notify_interval_q <= cfg_data[INTERVAL_BITS-1:0];
				reco_pkg::REG_SIG_BITS:        sig_bits_q        <= cfg_data[reco_pkg::SIG_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// held transaction moves on unless it has a result and the output register is stuck
	assign go       = valid_s1 && !(res.valid && out_valid_q && out_stall);
	assign in_stall = valid_s1 && !go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			cmd_s1             <= cmd;
			pin_a_s1           <= pin_a;
			pin_b_s1           <= pin_b;
			write_sign_s1      <= write_sign;
			write_magnitude_s1 <= write_magnitude;
		end
	end

	reco_engine #(
		.MAG_BITS      (MAG_BITS),
		.INTERVAL_BITS (INTERVAL_BITS)
	) u_engine (
		.clk                (clk),
		.arst_n             (arst_n),
		.go                 (go),
		.cmd                (cmd_s1),
		.pin_a              (pin_a_s1),
		.pin_b              (pin_b_s1),
		.write_sign         (write_sign_s1),
		.write_magnitude    (write_magnitude_s1),
		.sample_interval_us (sample_interval_q),
		.range_lower        (range_lower_q),
		.range_upper        (range_upper_q),
		.notify_enable      (notify_enable_q),
		.notify_interval_ms (notify_interval_q),
		.significant_bits   (sig_bits_q),
		.res                (res),
		.res_mag            (res_mag)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go && res.valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && res.valid) begin
			kind_q      <= res.kind;
			sign_q      <= res.sign;
			magnitude_q <= res_mag;
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign sign      = sign_q;
	assign magnitude = magnitude_q;

	`ASSERT_IMPLIES(a_no_overwrite, clk, arst_n, go && res.valid,
		!(out_valid_q && out_stall))

endmodule

FILE: src/reco_engine.sv
// ----------------------------------------------------------------------------
// reco_engine
// Counter state and the single-pass update for one command transaction.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module reco_engine #(
	parameter int MAG_BITS      = reco_pkg::MAG_BITS_DEF,
	parameter int INTERVAL_BITS = reco_pkg::INTERVAL_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         go,
	input  logic [1:0]                   cmd,
	input  logic                         pin_a,
	input  logic                         pin_b,
	input  logic                         write_sign,
	input  logic [MAG_BITS-1:0]          write_magnitude,
	input  logic [INTERVAL_BITS-1:0]     sample_interval_us,
	input  logic signed [MAG_BITS:0]     range_lower,
	input  logic signed [MAG_BITS:0]     range_upper,
	input  logic                         notify_enable,
	input  logic [INTERVAL_BITS-1:0]     notify_interval_ms,
	input  logic [reco_pkg::SIG_W-1:0]   significant_bits,
	output reco_pkg::res_ctrl_t          res,
	output logic [MAG_BITS-1:0]          res_mag
);

	localparam logic [INTERVAL_BITS:0] ELAPSED_CAP = {1'b1, {INTERVAL_BITS{1'b0}}};
	localparam logic [MAG_BITS-1:0]    MAG_ALL     = {MAG_BITS{1'b1}};
	localparam logic [5:0]             MAG_BITS_L  = 6'(MAG_BITS);

	logic                       prev_a_q, prev_b_q;
	logic signed [MAG_BITS:0]   position_q;
	logic                       last_sign_q;
	logic [MAG_BITS-1:0]        last_mag_q;
	logic [INTERVAL_BITS:0]     us_q, ms_q;

	logic [INTERVAL_BITS:0]     us_next, ms_next;
	logic                       sample, falling;
	logic signed [MAG_BITS+1:0] step, turned, clamped;
	logic [MAG_BITS:0]          abs_pos;
	logic                       now_sign;
	logic [MAG_BITS-1:0]        now_mag;
	logic [5:0]                 sig_n;
	logic [MAG_BITS-1:0]        mask;
	logic                       changed, notify;

	assign us_next = us_q[INTERVAL_BITS] ? us_q : us_q + 1'b1;
	assign ms_next = ms_q[INTERVAL_BITS] ? ms_q : ms_q + 1'b1;
	assign sample  = us_next > {1'b0, sample_interval_us};
	assign falling = prev_a_q & ~pin_a;

	// one step down when B was high, up when low, then clamp
	assign step   = prev_b_q ? '1 : (MAG_BITS+2)'(1);
	assign turned = {position_q[MAG_BITS], position_q} + step;

	always_comb begin
		if (turned < $signed({range_lower[MAG_BITS], range_lower})) begin
			clamped = $signed({range_lower[MAG_BITS], range_lower});
		end else if (turned > $signed({range_upper[MAG_BITS], range_upper})) begin
			clamped = $signed({range_upper[MAG_BITS], range_upper});
		end else begin
			clamped = turned;
		end
	end

	// sign-magnitude view of the count, magnitude saturated
	assign now_sign = position_q[MAG_BITS];
	assign abs_pos  = now_sign ? (MAG_BITS+1)'(-position_q) : position_q;
	assign now_mag  = abs_pos[MAG_BITS] ? MAG_ALL : abs_pos[MAG_BITS-1:0];

	assign sig_n   = ({1'b0, significant_bits} > MAG_BITS_L) ? MAG_BITS_L
		: {1'b0, significant_bits};
	assign mask    = ~(MAG_ALL >> sig_n);
	assign changed = (mask == '0) || (now_sign != last_sign_q)
		|| ((now_mag & mask) != (last_mag_q & mask));
	assign notify  = notify_enable && (ms_next > {1'b0, notify_interval_ms}) && changed;

	always_comb begin
		res.valid = 1'b0;
		res.kind  = reco_pkg::KIND_READ;
		res.sign  = now_sign;
		res_mag   = now_mag;
		unique case (cmd)
			reco_pkg::CMD_US_TICK: begin
				res.valid = 1'b0;
			end
			reco_pkg::CMD_MS_TICK: begin
				res.valid = notify;
				res.kind  = reco_pkg::KIND_NOTIFY;
			end
			reco_pkg::CMD_READ: begin
				res.valid = 1'b1;
				res.kind  = reco_pkg::KIND_READ;
			end
			reco_pkg::CMD_WRITE: begin
				res.valid = 1'b1;
				res.kind  = reco_pkg::KIND_ACK;
				res.sign  = write_sign;
				res_mag   = write_magnitude;
			end
			default: begin
				res.valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_a_q    <= 1'b1;
			prev_b_q    <= 1'b1;
			position_q  <= '0;
			last_sign_q <= 1'b0;
			last_mag_q  <= '0;
			us_q        <= '0;
			ms_q        <= '0;
		end else if (go) begin
			unique case (cmd)
				reco_pkg::CMD_US_TICK: begin
					if (sample) begin
						us_q     <= '0;
						prev_a_q <= pin_a;
						prev_b_q <= pin_b;
						if (falling) begin
							position_q <= clamped[MAG_BITS:0];
						end
					end else begin
						us_q <= us_next;
					end
				end
				reco_pkg::CMD_MS_TICK: begin
					if (notify) begin
						ms_q        <= '0;
						last_sign_q <= now_sign;
						last_mag_q  <= now_mag;
					end else begin
						ms_q <= ms_next;
					end
				end
				reco_pkg::CMD_WRITE: begin
					position_q <= write_sign ? -$signed({1'b0, write_magnitude})
						: $signed({1'b0, write_magnitude});
				end
				default: begin
				end
			endcase
		end
	end

	`ASSERT_NEXT(a_notify_clears_ms, clk, arst_n,
		go && res.valid && (res.kind == reco_pkg::KIND_NOTIFY), ms_q == '0)
	`ASSERT_IMPLIES(a_rw_gives_result, clk, arst_n,
		go && ((cmd == reco_pkg::CMD_READ) || (cmd == reco_pkg::CMD_WRITE)), res.valid)
	`ASSERT_IMPLIES(a_elapsed_capped, clk, arst_n, 1'b1,
		(us_q <= ELAPSED_CAP) && (ms_q <= ELAPSED_CAP))

endmodule
